// ===== sv/ghsd_pkg.sv =====
// ghsd_pkg: shared types and constants for the gait heel-strike detector
// no dependencies; imported by gait_heel_strike_detector
package ghsd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int TICK_WIDTH   = 16;
  localparam int THR_WIDTH    = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  // squares of sample differences and their three-term sum
  localparam int SQ_WIDTH  = 2 * SAMPLE_WIDTH;
  localparam int VAR_WIDTH = SQ_WIDTH + 2;

  localparam logic [CFG_IDX_W-1:0] REG_POLARITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd2;

  localparam logic [TICK_WIDTH-1:0] TICK_MAX       = '1;
  localparam logic [TICK_WIDTH-1:0] REFRACTORY_RST = 16'd160;
  localparam logic [THR_WIDTH-1:0]  THRESHOLD_RST  = 32'd50000;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] gyro_rate;
    logic signed [SAMPLE_WIDTH-1:0] accel_sample;
  } ghsd_in_t;

  typedef struct packed {
    logic heel_strike;
    logic armed;
  } ghsd_out_t;

endpackage

// ===== sv/gait_heel_strike_detector.sv =====
// gait_heel_strike_detector: gyro crossing arm plus accel variance strike test
// depends on ghsd_pkg
//
// Usage:
//   in_valid/in_stall carry one gyro and one accel sample per transfer.
//   out_valid/out_stall carry exactly one result per input transfer, in
//   order: heel_strike pulses on the detecting sample, armed shows the
//   detector state after that sample.
//   cfg_valid/cfg_ready write crossing_polarity (0), refractory_ticks (1)
//   and variance_threshold (2); cfg_ready is always high, other indexes
//   are ignored. Write only while no results are outstanding.
// Pipeline: one item per cycle unless the receiver stalls. Stage one forms
//   the squared accel differences and the gyro crossing test into its
//   registers, stage two updates the tick counter and armed flag, compares
//   the variance with the threshold and registers the result.
// Reset (rst, synchronous): histories, counter and armed flag clear,
//   registers return to polarity 0, refractory 160, threshold 50000.
// Receiver stall: the result register holds; stage one still accepts one
//   more item, after which in_stall rises until the result is taken.
module gait_heel_strike_detector
  import ghsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ghsd_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ghsd_out_t             out_result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic                  crossing_polarity;
  logic [TICK_WIDTH-1:0] refractory_ticks;
  logic [THR_WIDTH-1:0]  variance_threshold;

  // sample history, index 0 oldest
  logic signed [SAMPLE_WIDTH-1:0] gyro_history [3];
  logic signed [SAMPLE_WIDTH-1:0] accel_history [2];

  // stage one
  logic                s1_valid;
  logic                s1_cross;
  logic [SQ_WIDTH-1:0] s1_sq [3];

  // detector state
  logic [TICK_WIDTH-1:0] tick_counter;
  logic                  armed_flag;

  logic in_accept;
  logic adv;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_polarity  <= 1'b0;
      refractory_ticks   <= REFRACTORY_RST;
      variance_threshold <= THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POLARITY:   crossing_polarity  <= cfg_data[0];
        REG_REFRACTORY: refractory_ticks   <= cfg_data[TICK_WIDTH-1:0];
        REG_THRESHOLD:  variance_threshold <= cfg_data[THR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // stage one: crossing test on the four gyro samples, squared accel differences
  logic signed [SAMPLE_WIDTH-1:0] g0, g1, g2, g3;
  logic signed [SAMPLE_WIDTH-1:0] a0, a1, a2;
  logic                           cross_pos, cross_neg, cross_hit;
  logic [SQ_WIDTH-1:0]            sq_next [3];

  function automatic logic [SQ_WIDTH-1:0] sq_diff(
    input logic signed [SAMPLE_WIDTH-1:0] a,
    input logic signed [SAMPLE_WIDTH-1:0] b
  );
    logic signed [SAMPLE_WIDTH:0] d;
    logic [SAMPLE_WIDTH:0]        m;
    d = {a[SAMPLE_WIDTH-1], a} - {b[SAMPLE_WIDTH-1], b};
    m = d[SAMPLE_WIDTH] ? (~d + 1'b1) : d;
    // magnitude of a difference of two samples fits in SAMPLE_WIDTH bits
    return m[SAMPLE_WIDTH-1:0] * m[SAMPLE_WIDTH-1:0];
  endfunction

  always_comb begin
    g0 = gyro_history[0];
    g1 = gyro_history[1];
    g2 = gyro_history[2];
    g3 = in_data.gyro_rate;
    a0 = accel_history[0];
    a1 = accel_history[1];
    a2 = in_data.accel_sample;
    cross_pos = (g0 > 0) && (g1 > 0) && (g2 <= 0) && (g3 <= 0);
    cross_neg = (g0 < 0) && (g1 < 0) && (g2 >= 0) && (g3 >= 0);
    cross_hit = crossing_polarity ? cross_neg : cross_pos;
    sq_next[0] = sq_diff(a0, a1);
    sq_next[1] = sq_diff(a0, a2);
    sq_next[2] = sq_diff(a1, a2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      gyro_history[0]  <= '0;
      gyro_history[1]  <= '0;
      gyro_history[2]  <= '0;
      accel_history[0] <= '0;
      accel_history[1] <= '0;
    end else begin
      if (in_accept) begin
        s1_valid         <= 1'b1;
        gyro_history[0]  <= g1;
        gyro_history[1]  <= g2;
        gyro_history[2]  <= g3;
        accel_history[0] <= a1;
        accel_history[1] <= a2;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cross <= cross_hit;
      s1_sq[0] <= sq_next[0];
      s1_sq[1] <= sq_next[1];
      s1_sq[2] <= sq_next[2];
    end
  end

  // stage two: arm, count, variance compare
  logic                  arm;
  logic                  armed_mid;
  logic [TICK_WIDTH-1:0] tick_mid;
  logic [TICK_WIDTH-1:0] tick_counter_next;
  logic [VAR_WIDTH-1:0]  var9;
  logic [THR_WIDTH+3:0]  thr9;
  logic                  strike;
  logic                  armed_flag_next;

  always_comb begin
    arm       = s1_cross && (tick_counter > refractory_ticks);
    armed_mid = armed_flag || arm;
    tick_mid  = arm ? '0 : tick_counter;
    tick_counter_next = (tick_mid == TICK_MAX) ? tick_mid : tick_mid + 1'b1;
    var9 = VAR_WIDTH'(s1_sq[0]) + VAR_WIDTH'(s1_sq[1]) + VAR_WIDTH'(s1_sq[2]);
    thr9 = {variance_threshold, 3'b000} + (THR_WIDTH + 4)'(variance_threshold);
    strike = armed_mid && (var9 > thr9);
    armed_flag_next = armed_mid && !strike;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      armed_flag   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (adv) begin
        tick_counter <= tick_counter_next;
        armed_flag   <= armed_flag_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result.heel_strike <= strike;
      out_result.armed       <= armed_flag_next;
    end
  end

  // a strike always leaves the detector disarmed
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.heel_strike |-> !out_result.armed)
    else $error("heel strike reported while still armed");

  // arming restarts the counter, which then counts the arming sample
  assert property (@(posedge clk) disable iff (rst)
    adv && arm |=> tick_counter == TICK_WIDTH'(1))
    else $error("tick counter not restarted on arming");

  // the flag can only rise through a qualified crossing
  assert property (@(posedge clk) disable iff (rst)
    adv && !armed_flag && !arm |=> !armed_flag)
    else $error("armed flag set without a qualified crossing");

  // reported armed state tracks the detector flag
  assert property (@(posedge clk) disable iff (rst)
    adv |=> out_result.armed == armed_flag)
    else $error("result armed bit differs from detector state");

  // a held result is not overwritten
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !adv)
    else $error("stage two advanced into a stalled result");

endmodule

// ===== dv/tb.sv =====
// tb: self-checking bench for gait_heel_strike_detector
// predicts the strike and armed flags per sample and checks each result transfer in order
// depends on ghsd_pkg and the gait_heel_strike_detector rtl
`timescale 1ns / 1ps

module tb;
  import ghsd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {IDLE_FULL, IDLE_NONE, IDLE_LIGHT} idle_mode_t;

  // tracks gyro/accel windows, tick counter and armed flag; holds expected flags
  class strike_tracker;
    ghsd_out_t pending_flags[$];
    logic signed [SAMPLE_WIDTH-1:0] gyro_win[3];
    logic signed [SAMPLE_WIDTH-1:0] accel_win[2];
    logic [TICK_WIDTH-1:0] ticks;
    logic armed_now;
    logic polarity;
    logic [TICK_WIDTH-1:0] refractory;
    logic [THR_WIDTH-1:0] threshold;
    int errors;
    int results_seen;

    function new();
      foreach (gyro_win[i]) gyro_win[i] = '0;
      foreach (accel_win[i]) accel_win[i] = '0;
      ticks = '0;
      armed_now = 1'b0;
      polarity = 1'b0;
      refractory = REFRACTORY_RST;
      threshold = THRESHOLD_RST;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_POLARITY:   polarity = data[0];
        REG_REFRACTORY: refractory = data[TICK_WIDTH-1:0];
        REG_THRESHOLD:  threshold = data[THR_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned sq_gap(logic signed [SAMPLE_WIDTH-1:0] a,
                                     logic signed [SAMPLE_WIDTH-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return longint'(d * d);
    endfunction

    function void note_sample(ghsd_in_t s);
      logic signed [SAMPLE_WIDTH-1:0] g0, g1, g2, g3, a0, a1, a2;
      bit crossed;
      longint unsigned spread9;
      ghsd_out_t flags;
      g0 = gyro_win[0];
      g1 = gyro_win[1];
      g2 = gyro_win[2];
      g3 = s.gyro_rate;
      a0 = accel_win[0];
      a1 = accel_win[1];
      a2 = s.accel_sample;
      gyro_win[0] = g1;
      gyro_win[1] = g2;
      gyro_win[2] = g3;
      accel_win[0] = a1;
      accel_win[1] = a2;
      if (polarity == 1'b0) crossed = g0 > 0 && g1 > 0 && g2 <= 0 && g3 <= 0;
      else crossed = g0 < 0 && g1 < 0 && g2 >= 0 && g3 >= 0;
      if (crossed && ticks > refractory) begin
        armed_now = 1'b1;
        ticks = '0;
      end
      if (ticks != TICK_MAX) ticks = ticks + 1'b1;
      // nine times the variance, no division needed
      spread9 = sq_gap(a0, a1) + sq_gap(a0, a2) + sq_gap(a1, a2);
      flags.heel_strike = 1'b0;
      if (armed_now && spread9 > 64'd9 * threshold) begin
        flags.heel_strike = 1'b1;
        armed_now = 1'b0;
      end
      flags.armed = armed_now;
      pending_flags.push_back(flags);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_flags(ghsd_out_t got);
      ghsd_out_t want;
      if (pending_flags.size() == 0) begin
        report("result transfer with no sample pending");
        return;
      end
      want = pending_flags.pop_front();
      if (got.heel_strike !== want.heel_strike)
        report($sformatf("result %0d heel_strike got %b want %b",
                         results_seen, got.heel_strike, want.heel_strike));
      if (got.armed !== want.armed)
        report($sformatf("result %0d armed got %b want %b",
                         results_seen, got.armed, want.armed));
      results_seen++;
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  ghsd_in_t in_data;
  logic out_valid;
  logic out_stall;
  ghsd_out_t out_result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  strike_tracker tracker;
  idle_mode_t idle_mode;
  int gyro_run_left;
  bit gyro_positive;
  int accel_shift;
  int accel_base;

  gait_heel_strike_detector dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(6_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int draw_wait();
    case (idle_mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return $urandom_range(0, 3);
      default:    return $urandom_range(0, 19);
    endcase
  endfunction

  function automatic ghsd_in_t pack_sample(int g, int a);
    ghsd_in_t s;
    s.gyro_rate = SAMPLE_WIDTH'(g);
    s.accel_sample = SAMPLE_WIDTH'(a);
    return s;
  endfunction

  // alternating gyro sign runs like a swinging leg, with some zeros and noise
  function automatic ghsd_in_t gait_sample();
    ghsd_in_t s;
    int mag, acc, span;
    if (gyro_run_left == 0) begin
      gyro_positive = !gyro_positive;
      gyro_run_left = $urandom_range(1, 8);
    end
    gyro_run_left--;
    mag = $urandom_range(1, 1 << $urandom_range(0, 15));
    if ($urandom_range(0, 19) == 0) s.gyro_rate = SAMPLE_WIDTH'($urandom());
    else if ($urandom_range(0, 9) == 0) s.gyro_rate = '0;
    else if (gyro_positive) s.gyro_rate = (mag > 32767) ? 16'sd32767 : SAMPLE_WIDTH'(mag);
    else s.gyro_rate = SAMPLE_WIDTH'(-mag);
    span = 1 << accel_shift;
    acc = accel_base + int'($urandom_range(0, 2 * span)) - span;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    if ($urandom_range(0, 19) == 0) s.accel_sample = SAMPLE_WIDTH'($urandom());
    else s.accel_sample = SAMPLE_WIDTH'(acc);
    return s;
  endfunction

  task automatic send_sample(input ghsd_in_t s);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
    tracker.note_sample(s);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // hold off input until every expected result has been taken
  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (tracker.pending_flags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver side: random stall before each result transfer
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_flags(out_result);
  end

  initial begin
    logic pol;
    logic [TICK_WIDTH-1:0] refr;
    logic [THR_WIDTH-1:0] thr;
    int span;
    tracker = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_mode = IDLE_FULL;
    gyro_run_left = 0;
    gyro_positive = 1'b0;
    accel_shift = 8;
    accel_base = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: short refractory, upper data bits set, unused index
    write_cfg(REG_REFRACTORY, 32'd2);
    write_cfg(REG_POLARITY, 32'hFFFF_FFFE);
    write_cfg(REG_THRESHOLD, 32'd60000);
    write_cfg(REG_UNUSED, 32'hFFFF_FFFF);
    send_sample(pack_sample(32767, -32768));
    send_sample(pack_sample(32767, 32767));
    send_sample(pack_sample(-32768, -32768));
    // arm and strike on the same sample
    send_sample(pack_sample(0, 32767));
    send_sample(pack_sample(1, 0));
    send_sample(pack_sample(1, 0));
    send_sample(pack_sample(0, 0));
    send_sample(pack_sample(-1, 0));
    // crossing again while armed
    send_sample(pack_sample(5, 0));
    send_sample(pack_sample(5, 0));
    send_sample(pack_sample(-5, 0));
    send_sample(pack_sample(-5, 0));
    // variance exactly at the limit, then above it
    send_sample(pack_sample(-5, 300));
    send_sample(pack_sample(-5, -300));
    send_sample(pack_sample(-5, 301));
    drain_results();
    write_cfg(REG_POLARITY, 32'h0000_0003);
    write_cfg(REG_REFRACTORY, 32'hFFFF_0000);
    send_sample(pack_sample(-1, 0));
    send_sample(pack_sample(-1, 0));
    send_sample(pack_sample(0, 0));
    send_sample(pack_sample(0, 0));
    send_sample(pack_sample(32767, 32767));
    send_sample(pack_sample(-32768, 0));

    // refractory at its maximum: crossings never arm, back to back
    drain_results();
    write_cfg(REG_POLARITY, 32'd0);
    write_cfg(REG_REFRACTORY, 32'h0000_FFFF);
    write_cfg(REG_THRESHOLD, 32'd1000);
    idle_mode = IDLE_NONE;
    repeat (64) send_sample(pack_sample(100, 0));
    send_sample(pack_sample(-1, 0));
    send_sample(pack_sample(-1, 0));
    drain_results();
    write_cfg(REG_REFRACTORY, 32'(TICK_MAX - 1'b1));
    idle_mode = IDLE_FULL;
    send_sample(pack_sample(100, 0));
    send_sample(pack_sample(100, 0));
    send_sample(pack_sample(-1, 0));
    send_sample(pack_sample(-1, 0));
    send_sample(pack_sample(-1, 5000));

    // random gait-like phases, each under its own register setting
    for (int ph = 0; ph < 17; ph++) begin
      drain_results();
      accel_shift = $urandom_range(0, 15);
      accel_base = int'($urandom_range(0, 2000)) - 1000;
      span = 1 << accel_shift;
      pol = 1'($urandom_range(0, 1));
      case (ph)
        1: begin
          refr = '0;
          thr = '0;
        end
        2: begin
          refr = '1;
          thr = '1;
        end
        3: begin
          refr = REFRACTORY_RST;
          thr = THRESHOLD_RST;
        end
        default: begin
          if ($urandom_range(0, 7) == 0) refr = TICK_WIDTH'($urandom_range(0, 65535));
          else refr = TICK_WIDTH'($urandom_range(0, 12));
          if ($urandom_range(0, 3) == 0) thr = $urandom();
          else thr = $urandom_range(0, (span * span) / 2);
        end
      endcase
      write_cfg(REG_POLARITY, ($urandom() & 32'hFFFF_FFFE) | pol);
      write_cfg(REG_REFRACTORY, {16'($urandom()), refr});
      write_cfg(REG_THRESHOLD, thr);
      if ($urandom_range(0, 3) == 0) write_cfg(REG_UNUSED, $urandom());
      if (ph == 0) idle_mode = IDLE_FULL;
      else if (ph % 4 == 1) idle_mode = IDLE_NONE;
      else if (ph % 4 == 3) idle_mode = IDLE_LIGHT;
      else idle_mode = IDLE_FULL;
      repeat (100) send_sample(gait_sample());
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_flags.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ghsd_pkg.sv
sv/gait_heel_strike_detector.sv
dv/tb.sv
